// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned PendW    = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW     = $clog2(FifoDepth);
  localparam int unsigned LevelW   = $clog2(FifoDepth + 1);
  // room needed to take every result one byte can cause
  localparam int unsigned MaxRes   = 2;

  localparam logic [ByteW-1:0] AsciiMax = 8'h7f;
  localparam logic [ByteW-1:0] ContMax  = 8'hbf;
  localparam logic [ByteW-1:0] Lead2Max = 8'hdf;
  localparam logic [ByteW-1:0] Lead3Max = 8'hef;
  localparam logic [ByteW-1:0] Lead4Max = 8'hf7;
  localparam logic [ByteW-1:0] ContMask  = 8'h3f;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0f;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [CodeW-1:0] Replacement = 21'h00fffd;

  // continuation bytes still expected after a lead byte
  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  // number of results one byte causes
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_TWO  = 2'd2
  } res_cnt_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    res_cnt_t cnt;
    result_t  res0;
    result_t  res1;
  } dec_out_t;

  typedef struct packed {
    logic              has_room;
    logic [LevelW-1:0] level;
  } fifo_stat_t;

endpackage

// ===== rtl/utf8d_if.sv =====
interface utf8d_in_if;
  import utf8d_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
  import utf8d_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_point;
  logic             last_of_run;

  modport source (output valid, output code_point, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// ===== rtl/utf8d_decode.sv =====
module utf8d_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [utf8d_pkg::ByteW-1:0] text_byte,
  input  logic                       end_of_text,
  output utf8d_pkg::dec_out_t        dec
);
  import utf8d_pkg::*;

  logic [CodeW-1:0] partial_r, partial_nxt;
  logic [PendW-1:0] pend_r, pend_nxt;
  logic [PendW-1:0] pend_dec;
  logic [CodeW-1:0] shifted;

  assign pend_dec = pend_r - PendOne;
  assign shifted  = {partial_r[CodeW-7:0], text_byte[5:0] & ContMask[5:0]};

  // byte classification, state update and result assembly
  always_comb begin
    dec         = '0;
    dec.cnt     = RES_NONE;
    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    if (text_byte <= AsciiMax) begin
      if (pend_r != PendNone) begin
        dec.res0.code_point = Replacement;
        dec.res1.code_point = {{(CodeW-ByteW){1'b0}}, text_byte};
        dec.cnt             = RES_TWO;
      end else begin
        dec.res0.code_point = {{(CodeW-ByteW){1'b0}}, text_byte};
        dec.cnt             = RES_ONE;
      end
      pend_nxt = PendNone;
    end else if (text_byte <= ContMax) begin
      if (pend_r != PendNone) begin
        partial_nxt = shifted;
        pend_nxt    = pend_dec;
        if (pend_dec == PendNone) begin
          dec.res0.code_point = shifted;
          dec.cnt             = RES_ONE;
        end
      end else begin
        dec.res0.code_point = Replacement;
        dec.cnt             = RES_ONE;
      end
    end else if (text_byte <= Lead2Max) begin
      pend_nxt    = PendOne;
      partial_nxt = {{(CodeW-ByteW){1'b0}}, text_byte & Lead2Mask};
    end else if (text_byte <= Lead3Max) begin
      pend_nxt    = PendTwo;
      partial_nxt = {{(CodeW-ByteW){1'b0}}, text_byte & Lead3Mask};
    end else if (text_byte <= Lead4Max) begin
      pend_nxt    = PendThree;
      partial_nxt = {{(CodeW-ByteW){1'b0}}, text_byte & Lead4Mask};
    end else begin
      dec.res0.code_point = Replacement;
      dec.cnt             = RES_ONE;
      pend_nxt            = PendNone;
    end

    // unfinished sequence at end of text
    if (end_of_text) begin
      if (pend_nxt != PendNone) begin
        if (dec.cnt == RES_NONE) begin
          dec.res0.code_point = Replacement;
          dec.cnt             = RES_ONE;
        end else begin
          dec.res1.code_point = Replacement;
          dec.cnt             = RES_TWO;
        end
      end
      pend_nxt    = PendNone;
      partial_nxt = '0;
    end

    // mark the last result of this byte
    dec.res0.last_of_run = (dec.cnt == RES_ONE);
    dec.res1.last_of_run = (dec.cnt == RES_TWO);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pend_r    <= PendNone;
    end else if (fire) begin
      partial_r <= partial_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

// ===== rtl/utf8d_out_fifo.sv =====
module utf8d_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  utf8d_pkg::dec_out_t    dec,
  output utf8d_pkg::fifo_stat_t  stat,
  utf8d_out_if.source            out_bus
);
  import utf8d_pkg::*;

  result_t           mem_r [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [LevelW-1:0] level_r, level_nxt;
  logic [LevelW-1:0] n_push;
  logic              pop;
  logic [PtrW-1:0]   wr_ptr_p1;

  assign n_push    = push ? LevelW'(dec.cnt) : '0;
  assign pop       = out_bus.valid && out_bus.ready;
  assign level_nxt = level_r + n_push - LevelW'(pop);
  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);

  assign stat.level    = level_r;
  assign stat.has_room = (level_r <= LevelW'(FifoDepth - MaxRes));

  assign out_bus.valid       = (level_r != '0);
  assign out_bus.code_point  = mem_r[rd_ptr_r].code_point;
  assign out_bus.last_of_run = mem_r[rd_ptr_r].last_of_run;

  // result storage, up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (push && dec.cnt != RES_NONE) begin
      mem_r[wr_ptr_r] <= dec.res0;
    end
    if (push && dec.cnt == RES_TWO) begin
      mem_r[wr_ptr_p1] <= dec.res1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      level_r <= level_nxt;
    end
  end

endmodule

// ===== rtl/utf8_byte_decoder.sv =====
// Streaming UTF-8 decoder: one text byte in, zero to two code points out.
// in_bus carries text_byte and end_of_text; out_bus carries code_point and
// last_of_run, which is set on the final code point caused by a byte.
// Both channels use valid/ready; an item moves when both are high.
// A byte is captured in an input register, decoded there once the queue has
// room, and its results written to a four-entry result queue that drives out_bus.
// A byte passes through the input register and the result queue before its
// first result can be taken from out_bus.
// Throughput: one byte per cycle while the queue holds two or fewer
// entries; the queue drains one code point per cycle while out_bus.ready
// is high, so a byte that interrupts a sequence with ASCII (two results)
// fills the queue faster than it drains.
// When out_bus stalls, results collect in the queue; once it holds more
// than two entries a byte in the input register stays there and in_bus.ready
// drops. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the queue and input register and
// clears the partial code point and the pending continuation count.
module utf8_byte_decoder (
  input  logic         clk,
  input  logic         rst_n,
  utf8d_in_if.sink     in_bus,
  utf8d_out_if.source  out_bus
);
  import utf8d_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_eot_r;
  logic             in_fire;
  logic             dec_fire;
  dec_out_t         dec;
  fifo_stat_t       fstat;

  assign dec_fire     = s1_valid_r && fstat.has_room;
  assign in_bus.ready = !s1_valid_r || fstat.has_room;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (dec_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_bus.text_byte;
      s1_eot_r  <= in_bus.end_of_text;
    end
  end

  // byte decode and decoder state
  utf8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (dec_fire),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_eot_r),
    .dec         (dec)
  );

  // result queue
  utf8d_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (dec_fire),
    .dec     (dec),
    .stat    (fstat),
    .out_bus (out_bus)
  );

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= LevelW'(FifoDepth))
    else $error("result queue overfilled");

  // a byte blocked by a full queue stays in the input register
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !fstat.has_room) |=> s1_valid_r)
    else $error("blocked byte dropped");

  // two results: only the second closes the run
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && dec.cnt == RES_TWO) |-> (!dec.res0.last_of_run && dec.res1.last_of_run))
    else $error("bad last_of_run marking");

  // queue output valid tracks its fill level
  a_valid_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid == (fstat.level != '0))
    else $error("output valid disagrees with level");

endmodule
